/* rtl/core/rits_pkg.sv */
`timescale 1ns / 1ps

package rits_pkg;

	// configuration register indexes
	localparam logic [2:0] CFG_INTERVAL     = 3'd0;
	localparam logic [2:0] CFG_SUNDAY_EN    = 3'd1;
	localparam logic [2:0] CFG_WINDOW_EN    = 3'd2;
	localparam logic [2:0] CFG_WINDOW_START = 3'd3;
	localparam logic [2:0] CFG_WINDOW_END   = 3'd4;
	localparam logic [2:0] CFG_SUNDAY_CODE  = 3'd5;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;

	// result status codes
	localparam logic [2:0] STAT_READ_FAIL = 3'd0;
	localparam logic [2:0] STAT_INVALID   = 3'd1;
	localparam logic [2:0] STAT_BLOCKED   = 3'd2;
	localparam logic [2:0] STAT_OFF       = 3'd3;
	localparam logic [2:0] STAT_DUP       = 3'd4;
	localparam logic [2:0] STAT_FIRED     = 3'd5;

	// raw register masks
	localparam logic [7:0] MASK_SEC_MIN = 8'h7F;
	localparam logic [7:0] BIT_12H      = 8'h40;
	localparam logic [7:0] BIT_PM       = 8'h20;
	localparam logic [7:0] MASK_HOUR_12 = 8'h1F;
	localparam logic [7:0] MASK_HOUR_24 = 8'h3F;
	localparam logic [7:0] MASK_DATE    = 8'h3F;
	localparam logic [7:0] MASK_MONTH   = 8'h1F;
	localparam logic [7:0] MASK_DAY     = 8'h07;
	localparam logic [11:0] MIN_PER_HOUR = 12'd60;

	// minutes-of-day fit in 11 bits; one remainder step per bit
	localparam int TOTAL_W   = 11;
	localparam int DIV_STEPS = TOTAL_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	typedef struct packed {
		logic load;      // capture a new word
		logic div_step;  // one restoring remainder step
		logic emit;      // write the output register
	} rits_cmd_t;

	typedef struct packed {
		logic skip_div;  // status already settled at load
	} rits_sts_t;

	// high nibble * 10 + low nibble, nibbles above 9 allowed
	function automatic logic [7:0] bcd_value(input logic [7:0] b);
		logic [7:0] hi;
		hi = {4'd0, b[7:4]};
		return (hi << 3) + (hi << 1) + {4'd0, b[3:0]};
	endfunction

endpackage

/* rtl/core/rits_ctrl.sv */
`timescale 1ns / 1ps

module rits_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  rits_pkg::rits_sts_t sts,
	output rits_pkg::rits_cmd_t cmd
);
	import rits_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             out_free;
	logic             cnt_last;

	assign out_free = !out_valid_q || !out_stall;
	assign cnt_last = (cnt_q == CNT_W'(DIV_STEPS - 1));

	assign cmd.load     = (state_q == ST_IDLE) && in_valid;
	assign cmd.div_step = (state_q == ST_DIV) && !sts.skip_div;
	assign cmd.emit     = (state_q == ST_EMIT) && out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (in_valid)
						state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (sts.skip_div || cnt_last)
						state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* rtl/core/rits_dp.sv */
`timescale 1ns / 1ps

module rits_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [rits_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rits_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                read_ok,
	input  logic [7:0]                          rtc_sec,
	input  logic [7:0]                          rtc_min,
	input  logic [7:0]                          rtc_hour,
	input  logic [7:0]                          raw_day,
	input  logic [7:0]                          rtc_date,
	input  logic [7:0]                          rtc_month,
	input  logic [7:0]                          rtc_year,
	input  rits_pkg::rits_cmd_t                 cmd,
	output rits_pkg::rits_sts_t                 sts,
	output logic                                trigger,
	output logic [2:0]                          status,
	output logic [5:0]                          decoded_hour,
	output logic [6:0]                          decoded_minute
);
	import rits_pkg::*;

	// configuration
	logic [10:0] interval_q;
	logic        sunday_en_q;
	logic        window_en_q;
	logic [4:0]  win_start_q;
	logic [4:0]  win_end_q;
	logic [2:0]  sunday_code_q;

	// last fire stamp
	logic [7:0] last_hour_q, last_min_q, last_date_q, last_mon_q, last_year_q;

	// decode, combinational off the input word
	logic [7:0]  sec_d, min_d, hr_b, hr_d, day_d, date_d, mon_d, yr_d;
	logic        bad_d, gated_d;
	logic [2:0]  pre_st_d;
	logic        pre_final_d;
	logic [11:0] total_d;

	// working registers
	logic [5:0]         hr_q;
	logic [6:0]         mn_q;
	logic [4:0]         date_q;
	logic [3:0]         mon_q;
	logic [6:0]         yr_q;
	logic [2:0]         pre_st_q;
	logic               pre_final_q;
	logic [TOTAL_W-1:0] tot_sh_q;
	logic [TOTAL_W-1:0] divisor_q;
	logic [TOTAL_W-1:0] rem_q;

	logic [TOTAL_W:0]   rem_ext;
	logic [TOTAL_W-1:0] rem_next;
	logic               dup;
	logic [2:0]         final_st;

	// result register
	logic       trigger_q;
	logic [2:0] status_q;
	logic [5:0] out_hr_q;
	logic [6:0] out_mn_q;

	always_comb begin
		sec_d = bcd_value(rtc_sec & MASK_SEC_MIN);
		min_d = bcd_value(rtc_min & MASK_SEC_MIN);
		if ((rtc_hour & BIT_12H) != 8'd0) begin
			hr_b = bcd_value(rtc_hour & MASK_HOUR_12);
			if ((rtc_hour & BIT_PM) != 8'd0)
				hr_d = (hr_b != 8'd12) ? hr_b + 8'd12 : hr_b;
			else
				hr_d = (hr_b == 8'd12) ? 8'd0 : hr_b;
		end else begin
			hr_b = bcd_value(rtc_hour & MASK_HOUR_24);
			hr_d = hr_b;
		end
		day_d  = raw_day & MASK_DAY;
		date_d = bcd_value(rtc_date & MASK_DATE);
		mon_d  = bcd_value(rtc_month & MASK_MONTH);
		yr_d   = bcd_value(rtc_year);

		bad_d = (sec_d > 8'd59) || (min_d > 8'd59) || (hr_d > 8'd23) ||
			(day_d < 8'd1) || (day_d > 8'd7) || (date_d < 8'd1) || (date_d > 8'd31) ||
			(mon_d < 8'd1) || (mon_d > 8'd12) || (yr_d > 8'd99);
		gated_d = ((day_d[2:0] == sunday_code_q) && !sunday_en_q) ||
			(window_en_q && ((hr_d < {3'd0, win_start_q}) || (hr_d > {3'd0, win_end_q})));

		priority if (!read_ok) begin
			pre_st_d    = STAT_READ_FAIL;
			pre_final_d = 1'b1;
		end else if (bad_d) begin
			pre_st_d    = STAT_INVALID;
			pre_final_d = 1'b1;
		end else if (gated_d) begin
			pre_st_d    = STAT_BLOCKED;
			pre_final_d = 1'b1;
		end else begin
			pre_st_d    = STAT_OFF;
			pre_final_d = 1'b0;
		end

		total_d = {4'd0, hr_d} * MIN_PER_HOUR + {4'd0, min_d};
	end

	// restoring remainder step
	always_comb begin
		rem_ext = {rem_q, tot_sh_q[TOTAL_W-1]};
		if (rem_ext >= {1'b0, divisor_q})
			rem_next = TOTAL_W'(rem_ext - {1'b0, divisor_q});
		else
			rem_next = rem_ext[TOTAL_W-1:0];
	end

	assign dup = ({2'd0, hr_q} == last_hour_q) && ({1'b0, mn_q} == last_min_q) &&
		({3'd0, date_q} == last_date_q) && ({4'd0, mon_q} == last_mon_q) &&
		({1'b0, yr_q} == last_year_q);

	always_comb begin
		priority if (pre_final_q)
			final_st = pre_st_q;
		else if (rem_q != '0)
			final_st = STAT_OFF;
		else if (dup)
			final_st = STAT_DUP;
		else
			final_st = STAT_FIRED;
	end

	assign sts.skip_div = pre_final_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q    <= 11'd40;
			sunday_en_q   <= 1'b0;
			window_en_q   <= 1'b0;
			win_start_q   <= 5'd8;
			win_end_q     <= 5'd20;
			sunday_code_q <= 3'd1;
			last_hour_q   <= 8'hFF;
			last_min_q    <= 8'hFF;
			last_date_q   <= 8'hFF;
			last_mon_q    <= 8'hFF;
			last_year_q   <= 8'hFF;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_INTERVAL:     interval_q    <= cfg_data[10:0];
					CFG_SUNDAY_EN:    sunday_en_q   <= cfg_data[0];
					CFG_WINDOW_EN:    window_en_q   <= cfg_data[0];
					CFG_WINDOW_START: win_start_q   <= cfg_data[4:0];
					CFG_WINDOW_END:   win_end_q     <= cfg_data[4:0];
					CFG_SUNDAY_CODE:  sunday_code_q <= cfg_data[2:0];
					default: ;
				endcase
			end
			if (cmd.emit && (final_st == STAT_FIRED)) begin
				last_hour_q <= {2'd0, hr_q};
				last_min_q  <= {1'b0, mn_q};
				last_date_q <= {3'd0, date_q};
				last_mon_q  <= {4'd0, mon_q};
				last_year_q <= {1'b0, yr_q};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			// failed and invalid words report zero time
			hr_q        <= (pre_st_d == STAT_READ_FAIL || pre_st_d == STAT_INVALID) ?
				6'd0 : hr_d[5:0];
			mn_q        <= (pre_st_d == STAT_READ_FAIL || pre_st_d == STAT_INVALID) ?
				7'd0 : min_d[6:0];
			date_q      <= date_d[4:0];
			mon_q       <= mon_d[3:0];
			yr_q        <= yr_d[6:0];
			pre_st_q    <= pre_st_d;
			pre_final_q <= pre_final_d;
			tot_sh_q    <= total_d[TOTAL_W-1:0];
			divisor_q   <= (interval_q == 11'd0) ? 11'd1 : interval_q;
			rem_q       <= '0;
		end else if (cmd.div_step) begin
			rem_q    <= rem_next;
			tot_sh_q <= {tot_sh_q[TOTAL_W-2:0], 1'b0};
		end
		if (cmd.emit) begin
			trigger_q <= (final_st == STAT_FIRED);
			status_q  <= final_st;
			out_hr_q  <= hr_q;
			out_mn_q  <= mn_q;
		end
	end

	assign trigger        = trigger_q;
	assign status         = status_q;
	assign decoded_hour   = out_hr_q;
	assign decoded_minute = out_mn_q;

endmodule

/* rtl/core/rtc_interval_trigger_scheduler_core.sv */
`timescale 1ns / 1ps
// RTC interval trigger scheduler.
// Input channel (in_valid / in_stall): one word is a raw clock sample, seven BCD
// registers plus read_ok. Output channel (out_valid / out_stall): one word per
// input word with trigger, status and the decoded hour and minute.
// Configuration: cfg_we with cfg_index / cfg_data writes one register per cycle;
// write only while the block is idle.
// Flow: a word that fails the read, range or day/hour gate settles at capture
// and skips the remainder steps. A word that reaches the interval test runs an
// 11-step restoring remainder (one bit of minutes-of-day per cycle) before its
// result is written. One word is in work at a time; in_stall is high from
// acceptance until the result is written to the output register.
// The output register holds its word while out_stall is high; the block then
// waits in its emit step and keeps in_stall high until the register frees.
// Reset (arst_n low): configuration returns to its defaults (interval 40,
// Sunday blocked, window off, window 8..20, Sunday code 1), the last-fire stamp
// is cleared to all ones, and both channels go idle.
module rtc_interval_trigger_scheduler_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rits_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rits_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              read_ok,
	input  logic [7:0]                        rtc_sec,
	input  logic [7:0]                        rtc_min,
	input  logic [7:0]                        rtc_hour,
	input  logic [7:0]                        raw_day,
	input  logic [7:0]                        rtc_date,
	input  logic [7:0]                        rtc_month,
	input  logic [7:0]                        rtc_year,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              trigger,
	output logic [2:0]                        status,
	output logic [5:0]                        decoded_hour,
	output logic [6:0]                        decoded_minute
);
	import rits_pkg::*;

	rits_cmd_t cmd;
	rits_sts_t sts;

	// sequencer: capture, remainder steps, result write-back
	rits_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// decode, gates, remainder unit, duplicate stamp, output register
	rits_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.read_ok        (read_ok),
		.rtc_sec        (rtc_sec),
		.rtc_min        (rtc_min),
		.rtc_hour       (rtc_hour),
		.raw_day        (raw_day),
		.rtc_date       (rtc_date),
		.rtc_month      (rtc_month),
		.rtc_year       (rtc_year),
		.cmd            (cmd),
		.sts            (sts),
		.trigger        (trigger),
		.status         (status),
		.decoded_hour   (decoded_hour),
		.decoded_minute (decoded_minute)
	);

endmodule

/* rtl/core/rits_checker.sv */
`timescale 1ns / 1ps

module rits_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic       trigger,
	input logic [2:0] status,
	input logic [5:0] decoded_hour,
	input logic [6:0] decoded_minute
);
	import rits_pkg::*;

	// trigger goes with the fired status and nothing else
	a_trig_fired: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (trigger == (status == STAT_FIRED)))
		else $error("trigger and status disagree");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status <= STAT_FIRED))
		else $error("status code out of range");

	// failed or invalid reads report zero time
	a_zero_time: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == STAT_READ_FAIL || status == STAT_INVALID)) |->
		(decoded_hour == 6'd0 && decoded_minute == 7'd0))
		else $error("time reported on failed or invalid word");

	// one word in work at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken while a word is in work");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(trigger)))
		else $error("stalled output word changed");

endmodule

bind rtc_interval_trigger_scheduler_core rits_checker u_rits_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.trigger        (trigger),
	.status         (status),
	.decoded_hour   (decoded_hour),
	.decoded_minute (decoded_minute)
);
